[rtl/plso_pkg.sv]
// plso_pkg: shared types, constants and fixed-point helpers of the light splat core.
// No dependencies. Used by point_light_splat_occlusion_core.
`default_nettype none

package plso_pkg;

  // Operation codes carried on tuser
  localparam int OP_W = 2;
  localparam logic [OP_W-1:0] OP_SET_OCC = 2'd0;
  localparam logic [OP_W-1:0] OP_SPLAT   = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPOSE = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR   = 2'd3;

  // Configuration register indexes
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_WORLD_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WORLD_HEIGHT = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHTING_EN  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OCCLUSION_EN = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OCC_STRENGTH = 8'd4;
  localparam int CFG_DATA_W = 16;

  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 32;

  // Fixed-point constants
  localparam logic [16:0] T_ONE        = 17'd65536;
  localparam logic [15:0] STRENGTH_CAP = 16'd62259;
  localparam logic [16:0] TRANS_FLOOR  = 17'd655;
  localparam logic [15:0] AMBIENT_Q12  = 16'd1434;
  localparam logic [15:0] LIGHT_ONE    = 16'd4096;

  // Datapath widths
  localparam int CRD_W    = 12;  // signed cell coordinates incl. clipping overhang
  localparam int D2_W     = 18;  // squared distance
  localparam int RAD_W    = D2_W + 40;
  localparam int ROOT_W   = RAD_W / 2;
  localparam int SQ_STEPS = ROOT_W;
  localparam int RQ_W     = 12;

  typedef logic signed [CRD_W-1:0] crd_t;

  typedef struct packed {
    logic [15:0] blue;
    logic [15:0] green;
    logic [15:0] red;
  } light_t;

  // (p + 2040) / 4080 via floor(floor(n/16)/255), reciprocal estimate plus one correction
  function automatic logic [13:0] light_add(input logic [24:0] p);
    logic [24:0] n;
    logic [20:0] m;
    logic [29:0] me;
    logic [13:0] qe;
    logic [21:0] rem;
    n   = p + 25'd2040;
    m   = n[24:4];
    me  = {1'b0, m, 8'b0} + {9'b0, m};
    qe  = me[29:16];
    rem = {1'b0, m} - ({qe, 8'b0} - {8'b0, qe});
    return (rem >= 22'd255) ? qe + 14'd1 : qe;
  endfunction

  // Saturating Q4.12 accumulate
  function automatic logic [15:0] light_sat(input logic [15:0] acc, input logic [13:0] add);
    logic [16:0] s;
    s = {1'b0, acc} + {3'b0, add};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  // One channel of compose shading
  function automatic logic [7:0] shade(input logic [7:0] b, input logic [15:0] lt);
    logic [12:0] m;
    logic [20:0] v;
    logic [20:0] r;
    if (lt > LIGHT_ONE) m = 13'(LIGHT_ONE);
    else if (lt < AMBIENT_Q12) m = 13'(AMBIENT_Q12);
    else m = lt[12:0];
    v = {13'b0, b} * {8'b0, m};
    r = (v + 21'd2048) >> 12;
    return (r > 21'd255) ? 8'd255 : r[7:0];
  endfunction

endpackage

`default_nettype wire

[rtl/point_light_splat_occlusion_core.sv]
// Point light splat core with Bresenham occlusion: occupancy map and RGB light store.
// Depends on plso_pkg and plso_ram.
//
// channel   | dir | payload
// s_axis    | in  | tuser: op; tdata: pos, occupied, radius, color, base_color
// m_axis    | out | tdata: pixel_color (compose only)
// cfg       | in  | cfg_index, cfg_data; always ready
//
// Set occupancy writes the map in the cycle it is accepted. Compose reads the light
// store, then waits for a free output slot. Clear light: one light-store entry per
// cycle. Splat: a setup state, then per pixel of the clipped square a skip when out
// of radius, else pixel step, 29-step root, 29-step divide, intensity, the shadow walk
// (an occupancy read on every second cell), attenuation and the read-modify-write.
// Synchronous reset runs a clear sweep of both memories, during which no request is
// taken. A waiting result does not block new requests.
`default_nettype none

module point_light_splat_occlusion_core #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_RADIUS = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // pos_x[7:0] pos_y[15:8] occupied[16] radius_q4[26:17] light_red[34:27]
  // light_green[42:35] light_blue[50:43] base_color[82:51], zero pad to 88
  input  logic [plso_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // op[1:0]
  input  logic [plso_pkg::OP_W-1:0]          s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // pixel_color[31:0]
  output logic [plso_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [plso_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [plso_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import plso_pkg::*;

  localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(CELLS);
  localparam logic [8:0]      MAXW9    = 9'((MAX_WIDTH > 511) ? 511 : MAX_WIDTH);
  localparam logic [8:0]      MAXH9    = 9'((MAX_HEIGHT > 511) ? 511 : MAX_HEIGHT);
  localparam logic [RQ_W-1:0] RQ_MAX   = RQ_W'(MAX_RADIUS * 16);
  localparam logic [AW-1:0]   ROW_STEP = AW'(MAX_WIDTH);
  localparam logic [AW-1:0]   LAST_A   = AW'(CELLS - 1);

  localparam logic [3:0] S_CLR     = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_SETUP   = 4'd2;
  localparam logic [3:0] S_PIX     = 4'd3;
  localparam logic [3:0] S_SQRT    = 4'd4;
  localparam logic [3:0] S_DIV     = 4'd5;
  localparam logic [3:0] S_INT     = 4'd6;
  localparam logic [3:0] S_WALK    = 4'd7;
  localparam logic [3:0] S_WALK_RD = 4'd8;
  localparam logic [3:0] S_ATTN    = 4'd9;
  localparam logic [3:0] S_PROD    = 4'd10;
  localparam logic [3:0] S_ADD     = 4'd11;
  localparam logic [3:0] S_CMP_RD  = 4'd12;
  localparam logic [3:0] S_CMP_OUT = 4'd13;

  function automatic logic [AW-1:0] cell_addr(input logic [8:0] x, input logic [8:0] y);
    return AW'(AW'(y) * ROW_STEP + AW'(x));
  endfunction

  // configuration
  logic [8:0]  world_width, world_height;
  logic        lighting_en, occlusion_en;
  logic [15:0] occ_strength;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      world_width  <= 9'd256;
      world_height <= 9'd256;
      lighting_en  <= 1'b1;
      occlusion_en <= 1'b1;
      occ_strength <= 16'd32768;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WORLD_WIDTH:  world_width  <= cfg_data[8:0];
        REG_WORLD_HEIGHT: world_height <= cfg_data[8:0];
        REG_LIGHTING_EN:  lighting_en  <= cfg_data[0];
        REG_OCCLUSION_EN: occlusion_en <= cfg_data[0];
        REG_OCC_STRENGTH: occ_strength <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [8:0] ww_nz, wh_nz, eff_w, eff_h;
  assign ww_nz = (world_width == 9'd0) ? 9'd1 : world_width;
  assign wh_nz = (world_height == 9'd0) ? 9'd1 : world_height;
  assign eff_w = (ww_nz > MAXW9) ? MAXW9 : ww_nz;
  assign eff_h = (wh_nz > MAXH9) ? MAXH9 : wh_nz;

  // input fields
  logic [OP_W-1:0] in_op;
  logic [7:0]      in_x, in_y, in_r, in_g, in_b;
  logic            in_occ;
  logic [9:0]      in_rad;
  logic [31:0]     in_base;
  logic            in_world, accept;
  logic [RQ_W-1:0] in_rad12, in_rq;

  assign in_op    = s_axis_tuser;
  assign in_x     = s_axis_tdata[7:0];
  assign in_y     = s_axis_tdata[15:8];
  assign in_occ   = s_axis_tdata[16];
  assign in_rad   = s_axis_tdata[26:17];
  assign in_r     = s_axis_tdata[34:27];
  assign in_g     = s_axis_tdata[42:35];
  assign in_b     = s_axis_tdata[50:43];
  assign in_base  = s_axis_tdata[82:51];
  assign in_world = ({1'b0, in_x} < eff_w) && ({1'b0, in_y} < eff_h);
  assign in_rad12 = {2'b00, in_rad};
  assign in_rq    = (in_rad12 < 12'd16) ? 12'd16 : ((in_rad12 > RQ_MAX) ? RQ_MAX : in_rad12);

  logic [3:0] state, state_next;
  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // splat registers
  crd_t            ex, ey, px, py, min_x, max_x, min_y, max_y;
  logic [RQ_W-1:0] rq;
  logic [7:0]      col_r, col_g, col_b;
  logic [23:0]     rq2;
  logic [16:0]     factor;
  // root / divide unit
  logic [RAD_W-1:0]  rad;
  logic [30:0]       srem;
  logic [ROOT_W-1:0] root;
  logic [RQ_W-1:0]   drem;
  logic [4:0]        cnt;
  // walk
  crd_t        wx, wy, wdx, wdy, err;
  logic        wsx, wsy, odd;
  logic [16:0] t, inten_i, inten;
  logic [24:0] prod_r, prod_g, prod_b;
  // clear / compose
  logic [AW-1:0] clr_addr, cmp_addr;
  logic          clr_occ, cmp_in;
  logic [31:0]   cmp_base;
  logic          out_load;
  logic [31:0]   out_data;

  // setup
  logic [7:0]  ri;
  crd_t        ri_c, lo_x, hi_x, lo_y, hi_y, wmax, hmax;
  logic [15:0] s_cap;
  logic [23:0] rq2_c;
  assign ri    = 8'((rq + 12'd15) >> 4);
  assign ri_c  = crd_t'({4'b0, ri});
  assign lo_x  = ex - ri_c;
  assign hi_x  = ex + ri_c;
  assign lo_y  = ey - ri_c;
  assign hi_y  = ey + ri_c;
  assign wmax  = crd_t'({3'b0, eff_w}) - 12'sd1;
  assign hmax  = crd_t'({3'b0, eff_h}) - 12'sd1;
  assign s_cap = (occ_strength > STRENGTH_CAP) ? STRENGTH_CAP : occ_strength;
  assign rq2_c = {12'b0, rq} * {12'b0, rq};

  // pixel
  crd_t        ddx, ddy;
  logic [7:0]  adx, ady;
  logic [17:0] adx18, ady18, d2;
  logic        skip;
  logic [AW-1:0] pix_addr;
  assign ddx      = px - ex;
  assign ddy      = py - ey;
  assign adx      = (ddx < 12'sd0) ? 8'(-ddx) : 8'(ddx);
  assign ady      = (ddy < 12'sd0) ? 8'(-ddy) : 8'(ddy);
  assign adx18    = {10'b0, adx};
  assign ady18    = {10'b0, ady};
  assign d2       = adx18 * adx18 + ady18 * ady18;
  assign skip     = {d2, 8'b0} > {2'b0, rq2};
  assign pix_addr = cell_addr(px[8:0], py[8:0]);

  logic last_x, last_y;
  assign last_x = (px == max_x);
  assign last_y = (py == max_y);

  // root step
  logic [32:0] sq_try, sq_trial;
  logic        sq_ge;
  assign sq_try   = {srem, rad[RAD_W-1 -: 2]};
  assign sq_trial = {2'b00, root, 2'b01};
  assign sq_ge    = sq_try >= sq_trial;

  // divide step
  logic [RQ_W:0] dv_try;
  logic          dv_ge;
  assign dv_try = {drem, root[ROOT_W-1]};
  assign dv_ge  = dv_try >= {1'b0, rq};

  // intensity
  logic [16:0] ratio, lin, ilin, att;
  logic [33:0] lin_sq, att_p, tm;
  logic [16:0] t_mul;
  assign ratio  = (root > ROOT_W'(T_ONE)) ? T_ONE : root[16:0];
  assign lin    = T_ONE - ratio;
  assign lin_sq = {17'b0, lin} * {17'b0, lin};
  assign ilin   = 17'((lin_sq + 34'd32768) >> 16);
  assign att_p  = {17'b0, inten_i} * {17'b0, t};
  assign att    = 17'((att_p + 34'd32768) >> 16);
  assign tm     = {17'b0, t} * {17'b0, factor};
  assign t_mul  = 17'((tm + 34'd32768) >> 16);

  // Bresenham step
  crd_t e2, nx, ny, nerr1, nerr;
  logic at_tgt, reached;
  assign e2      = err <<< 1;
  assign nx      = (e2 >= wdy) ? (wsx ? wx + 12'sd1 : wx - 12'sd1) : wx;
  assign nerr1   = (e2 >= wdy) ? err + wdy : err;
  assign ny      = (e2 <= wdx) ? (wsy ? wy + 12'sd1 : wy - 12'sd1) : wy;
  assign nerr    = (e2 <= wdx) ? nerr1 + wdx : nerr1;
  assign at_tgt  = (wx == px) && (wy == py);
  assign reached = (nx == px) && (ny == py);

  // memories
  logic          oc_re, oc_we, oc_wd, oc_rd;
  logic [AW-1:0] oc_addr;
  logic          lt_re, lt_we;
  logic [AW-1:0] lt_addr;
  light_t        lt_wd, lt_rd, lt_new;

  assign lt_new.red   = light_sat(lt_rd.red,   light_add(prod_r));
  assign lt_new.green = light_sat(lt_rd.green, light_add(prod_g));
  assign lt_new.blue  = light_sat(lt_rd.blue,  light_add(prod_b));

  plso_ram #(.WIDTH(1), .DEPTH(CELLS)) u_occ_ram (
    .clk(clk), .rd_en(oc_re), .wr_en(oc_we), .addr(oc_addr),
    .wr_data(oc_wd), .rd_data(oc_rd)
  );

  plso_ram #(.WIDTH($bits(light_t)), .DEPTH(CELLS)) u_light_ram (
    .clk(clk), .rd_en(lt_re), .wr_en(lt_we), .addr(lt_addr),
    .wr_data(lt_wd), .rd_data(lt_rd)
  );

  always_comb begin
    oc_re   = 1'b0;
    oc_we   = 1'b0;
    oc_wd   = 1'b0;
    oc_addr = clr_addr;
    lt_re   = 1'b0;
    lt_we   = 1'b0;
    lt_wd   = '0;
    lt_addr = clr_addr;
    unique case (state)
      S_CLR: begin
        lt_we = 1'b1;
        oc_we = clr_occ;
      end
      S_IDLE: begin
        oc_addr = cell_addr({1'b0, in_x}, {1'b0, in_y});
        oc_wd   = in_occ;
        oc_we   = accept && (in_op == OP_SET_OCC) && in_world;
      end
      S_WALK: begin
        oc_addr = cell_addr(nx[8:0], ny[8:0]);
        oc_re   = !at_tgt && !reached && odd;
      end
      S_PROD: begin
        lt_addr = pix_addr;
        lt_re   = (inten != 17'd0);
      end
      S_ADD: begin
        lt_addr = pix_addr;
        lt_we   = 1'b1;
        lt_wd   = lt_new;
      end
      S_CMP_RD: begin
        lt_addr = cmp_addr;
        lt_re   = cmp_in;
      end
      default: ;
    endcase
  end

  // compose result
  light_t cmp_lt;
  assign cmp_lt   = cmp_in ? lt_rd : '0;
  assign out_data = !lighting_en ? cmp_base :
                    {shade(cmp_base[31:24], cmp_lt.red), shade(cmp_base[23:16], cmp_lt.green),
                     shade(cmp_base[15:8], cmp_lt.blue), cmp_base[7:0]};
  assign out_load = (state == S_CMP_OUT) && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= out_data;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLR:     if (clr_addr == LAST_A) state_next = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          case (in_op)
            OP_SPLAT:   if (lighting_en && in_world) state_next = S_SETUP;
            OP_COMPOSE: state_next = S_CMP_RD;
            OP_CLEAR:   state_next = S_CLR;
            default: ;
          endcase
        end
      end
      S_SETUP:   state_next = S_PIX;
      S_PIX: begin
        if (!skip) state_next = S_SQRT;
        else if (last_x && last_y) state_next = S_IDLE;
      end
      S_SQRT:    if (cnt == 5'(SQ_STEPS - 1)) state_next = S_DIV;
      S_DIV:     if (cnt == 5'(ROOT_W - 1)) state_next = S_INT;
      S_INT:     state_next = occlusion_en ? S_WALK : S_ATTN;
      S_WALK: begin
        if (at_tgt || reached) state_next = S_ATTN;
        else if (odd) state_next = S_WALK_RD;
      end
      S_WALK_RD: begin
        if (oc_rd && t_mul <= TRANS_FLOOR) state_next = S_ATTN;
        else state_next = S_WALK;
      end
      S_ATTN:    state_next = S_PROD;
      S_PROD: begin
        if (inten != 17'd0) state_next = S_ADD;
        else if (last_x && last_y) state_next = S_IDLE;
        else state_next = S_PIX;
      end
      S_ADD:     state_next = (last_x && last_y) ? S_IDLE : S_PIX;
      S_CMP_RD:  state_next = S_CMP_OUT;
      S_CMP_OUT: if (out_load) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      clr_addr <= '0;
      clr_occ  <= 1'b1;
    end else begin
      state <= state_next;
      if (state == S_CLR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (accept && in_op == OP_CLEAR) begin
        clr_addr <= '0;
        clr_occ  <= 1'b0;
      end
    end
  end

  // advance the pixel cursor after a pixel is finished
  logic pix_done;
  assign pix_done = ((state == S_PIX) && skip) || (state == S_ADD) ||
                    ((state == S_PROD) && (inten == 17'd0));

  always_ff @(posedge clk) begin
    if (accept) begin
      ex       <= crd_t'({4'b0, in_x});
      ey       <= crd_t'({4'b0, in_y});
      rq       <= in_rq;
      col_r    <= in_r;
      col_g    <= in_g;
      col_b    <= in_b;
      cmp_addr <= cell_addr({1'b0, in_x}, {1'b0, in_y});
      cmp_in   <= in_world;
      cmp_base <= in_base;
    end
    if (state == S_SETUP) begin
      min_x  <= (lo_x < 12'sd0) ? 12'sd0 : lo_x;
      max_x  <= (hi_x > wmax) ? wmax : hi_x;
      min_y  <= (lo_y < 12'sd0) ? 12'sd0 : lo_y;
      max_y  <= (hi_y > hmax) ? hmax : hi_y;
      px     <= (lo_x < 12'sd0) ? 12'sd0 : lo_x;
      py     <= (lo_y < 12'sd0) ? 12'sd0 : lo_y;
      rq2    <= rq2_c;
      factor <= T_ONE - {1'b0, s_cap};
    end
    if (pix_done && !(last_x && last_y)) begin
      if (last_x) begin
        px <= min_x;
        py <= py + 12'sd1;
      end else begin
        px <= px + 12'sd1;
      end
    end
    case (state)
      S_PIX: begin
        rad  <= {d2, 40'b0};
        srem <= '0;
        root <= '0;
        cnt  <= '0;
        wx   <= ex;
        wy   <= ey;
        wsx  <= ex < px;
        wsy  <= ey < py;
        wdx  <= crd_t'({4'b0, adx});
        wdy  <= -crd_t'({4'b0, ady});
        err  <= crd_t'({4'b0, adx}) - crd_t'({4'b0, ady});
        odd  <= 1'b0;
        t    <= T_ONE;
      end
      S_SQRT: begin
        rad  <= rad << 2;
        srem <= sq_ge ? 31'(sq_try - sq_trial) : sq_try[30:0];
        root <= {root[ROOT_W-2:0], sq_ge};
        cnt  <= (cnt == 5'(SQ_STEPS - 1)) ? 5'd0 : cnt + 5'd1;
        if (cnt == 5'(SQ_STEPS - 1)) begin
          drem <= '0;
        end
      end
      S_DIV: begin
        drem <= dv_ge ? RQ_W'(dv_try - {1'b0, rq}) : dv_try[RQ_W-1:0];
        root <= {root[ROOT_W-2:0], dv_ge};
        cnt  <= cnt + 5'd1;
      end
      S_INT: begin
        inten_i <= ilin;
      end
      S_WALK: begin
        if (!at_tgt) begin
          wx  <= nx;
          wy  <= ny;
          err <= nerr;
          odd <= ~odd;
        end
      end
      S_WALK_RD: begin
        if (oc_rd) begin
          t <= (t_mul <= TRANS_FLOOR) ? 17'd0 : t_mul;
        end
      end
      S_ATTN: begin
        inten <= att;
      end
      S_PROD: begin
        prod_r <= {17'b0, col_r} * {8'b0, inten};
        prod_g <= {17'b0, col_g} * {8'b0, inten};
        prod_b <= {17'b0, col_b} * {8'b0, inten};
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLR) |-> !s_axis_tready)
    else $error("request taken during clear sweep");

  a_walk_read_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK_RD) |-> ($past(state) == S_WALK) && $past(odd))
    else $error("occupancy read outside an even walk step");

  a_rmw_pairing: assert property (@(posedge clk) disable iff (rst)
    (state == S_ADD) |-> ($past(state) == S_PROD) && ($past(inten) != 17'd0))
    else $error("light write without its read");

  a_trans_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_ATTN) |-> (t <= T_ONE))
    else $error("transmittance above one");

  a_cursor_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == S_PIX) |-> (px >= min_x) && (px <= max_x) && (py >= min_y) && (py <= max_y))
    else $error("pixel cursor left the clipped square");
`endif

endmodule

`default_nettype wire

[rtl/plso_ram.sv]
// plso_ram: generic single-port synchronous RAM with a registered read.
// No dependencies.
`default_nettype none

module plso_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wr_data,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end else if (rd_en) begin
      rd_data <= mem[addr];
    end
  end

endmodule

`default_nettype wire
